// ===== sv/eight_bit_cpu_load_rotate_core_top_macros.svh =====
// Assertion macros for the load/rotate core.
`ifndef EIGHT_BIT_CPU_LOAD_ROTATE_CORE_TOP_MACROS_SVH
`define EIGHT_BIT_CPU_LOAD_ROTATE_CORE_TOP_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== sv/elrc_pkg.sv =====
`default_nettype none
package elrc_pkg;
  localparam logic [15:0] HighPage = 16'hFF00;
  localparam logic [15:0] SpReset = 16'hFFFE;
  localparam logic [15:0] AfReset = 16'h11B0;
  localparam logic [15:0] BcReset = 16'h0013;
  localparam logic [15:0] DeReset = 16'h00D8;
  localparam logic [15:0] HlReset = 16'h014D;
  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegC = 3'd1;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;
  localparam logic [2:0] RegF = 3'd6;
  localparam logic [2:0] RegA = 3'd7;
  localparam logic [7:0] FlagZ = 8'h80;
  localparam logic [7:0] FlagN = 8'h40;
  localparam logic [7:0] FlagH = 8'h20;
  localparam logic [7:0] FlagC = 8'h10;

  typedef struct packed {
    logic [15:0] address;
    logic        write;
    logic [7:0]  wr_byte;
    logic        idle;
    logic        fetch;
    logic        halted;
    logic        bad_opcode;
  } bus_t;
endpackage
`default_nettype wire

// ===== sv/elrc_core.sv =====
`default_nettype none
`include "eight_bit_cpu_load_rotate_core_top_macros.svh"
module elrc_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          step,
  input  wire logic          enable,
  input  wire logic [7:0]    rd_byte,
  output elrc_pkg::bus_t     bus
);
  import elrc_pkg::*;

  logic [7:0]  regs [8];
  logic [7:0]  regs_next [8];
  logic [15:0] sp, sp_next, pc, pc_next, tw, tw_next;
  logic [7:0]  ir, ir_next;
  logic [2:0]  sc, sc_next;
  logic        stopf, stopf_next, fault, fault_next;

  logic [7:0]  op, d, f, v;
  logic [2:0]  r, src, s;
  logic [1:0]  pr;
  logic [15:0] hlw, prw, a16, e16;
  logic        rstop;
  logic [8:0]  csum;
  logic [4:0]  hsum;
  logic [7:0]  cout;
  bus_t        b;

  function automatic logic [15:0] pget(input logic [1:0] i, input logic [7:0] rg [8],
                                       input logic [15:0] spv);
    logic [15:0] res;
    case (i)
      2'd0: res = {rg[0], rg[1]};
      2'd1: res = {rg[2], rg[3]};
      2'd2: res = {rg[4], rg[5]};
      default: res = spv;
    endcase
    return res;
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) regs_next[i] = regs[i];
    sp_next = sp; pc_next = pc; tw_next = tw; ir_next = ir; sc_next = sc;
    stopf_next = stopf; fault_next = fault;
    b = '0;
    d = rd_byte;
    op = ir; s = sc; r = '0; src = '0; pr = '0; hlw = '0; prw = '0; a16 = '0; e16 = '0;
    f = '0; v = '0; rstop = 1'b0; csum = '0; hsum = '0; cout = '0;
    if (!enable || stopf || fault) begin
      b.idle = 1'b1;
    end else if (sc == 3'd0) begin
      b.address = pc; b.fetch = 1'b1; pc_next = pc + 16'd1; sc_next = 3'd1;
    end else begin
      if (s == 3'd1) begin
        ir_next = d;
        op = d;
      end
      sc_next = s + 3'd1;
      r = op[5:3]; pr = op[5:4]; src = op[2:0];
      hlw = {regs[RegH], regs[RegL]};
      prw = pget(pr, regs, sp);
      rstop = (op[2:0] == 3'd7);
      if (op[7:6] == 2'b01 && op != 8'h76) begin
        if (src == 3'd6) begin
          if (s == 3'd1) b.address = hlw;
          else begin regs_next[r] = d; b.fetch = 1'b1; end
        end else if (r == 3'd6) begin
          if (s == 3'd1) begin
            b.address = hlw; b.write = 1'b1; b.wr_byte = regs[src];
          end else b.fetch = 1'b1;
        end else begin
          regs_next[r] = regs[src]; b.fetch = 1'b1;
        end
      end else if ((op & 8'hCF) == 8'h01) begin
        if (s == 3'd1) begin b.address = pc; pc_next = pc + 16'd1; end
        else if (s == 3'd2) begin tw_next = {8'h00, d}; b.address = pc; pc_next = pc + 16'd1; end
        else begin
          a16 = {d, tw[7:0]};
          if (pr == 2'd3) sp_next = a16;
          else begin regs_next[{pr, 1'b0}] = a16[15:8]; regs_next[{pr, 1'b1}] = a16[7:0]; end
          b.fetch = 1'b1;
        end
      end else if ((op & 8'hCF) == 8'h03 || (op & 8'hCF) == 8'h0B) begin
        if (s == 3'd1) begin
          a16 = op[3] ? prw - 16'd1 : prw + 16'd1;
          if (pr == 2'd3) sp_next = a16;
          else begin regs_next[{pr, 1'b0}] = a16[15:8]; regs_next[{pr, 1'b1}] = a16[7:0]; end
          b.idle = 1'b1;
        end else b.fetch = 1'b1;
      end else if ((op & 8'hC7) == 8'h06) begin
        if (s == 3'd1) begin b.address = pc; pc_next = pc + 16'd1; end
        else if (r != 3'd6) begin regs_next[r] = d; b.fetch = 1'b1; end
        else if (s == 3'd2) begin b.address = hlw; b.write = 1'b1; b.wr_byte = d; end
        else b.fetch = 1'b1;
      end else if ((op & 8'hC6) == 8'h04) begin
        if (r != 3'd6) begin
          v = regs[r];
          if (op[0]) begin
            f = FlagN | ((v[3:0] == 4'h0) ? FlagH : 8'h00); v = v - 8'd1;
          end else begin
            f = (v[3:0] == 4'hF) ? FlagH : 8'h00; v = v + 8'd1;
          end
          if (v == 8'h00) f = f | FlagZ;
          regs_next[r] = v;
          regs_next[RegF] = (regs[RegF] & ~(FlagZ | FlagN | FlagH)) | f;
          if (r == RegF) regs_next[RegF] = (v & ~(FlagZ | FlagN | FlagH)) | f;
        end
        b.fetch = 1'b1;
      end else if ((op & 8'hCB) == 8'hC1 || (op & 8'hC7) == 8'hC7) begin
        if (op[3:0] == 4'h1) begin
          if (s == 3'd1) begin b.address = sp; sp_next = sp + 16'd1; end
          else if (s == 3'd2) begin
            tw_next = {8'h00, d}; b.address = sp; sp_next = sp + 16'd1;
          end else begin
            if (pr == 2'd3) begin regs_next[RegA] = d; regs_next[RegF] = tw[7:0] & 8'hF0; end
            else begin regs_next[{pr, 1'b0}] = d; regs_next[{pr, 1'b1}] = tw[7:0]; end
            b.fetch = 1'b1;
          end
        end else if (s == 3'd1) begin
          if (rstop) tw_next = pc;
          else if (pr == 2'd3) tw_next = {regs[RegA], regs[RegF]};
          else tw_next = prw;
          b.idle = 1'b1;
        end else if (s == 3'd2) begin
          sp_next = sp - 16'd1;
          b.address = sp - 16'd1; b.write = 1'b1; b.wr_byte = tw[15:8];
        end else if (s == 3'd3) begin
          sp_next = sp - 16'd1;
          b.address = sp - 16'd1; b.write = 1'b1; b.wr_byte = tw[7:0];
        end else begin
          if (rstop) pc_next = {10'd0, op[5:3], 3'd0};
          b.fetch = 1'b1;
        end
      end else begin
        case (op)
          8'h00: b.fetch = 1'b1;
          8'h10: begin stopf_next = 1'b1; b.idle = 1'b1; end
          8'h07, 8'h0F, 8'h17, 8'h1F: begin
            v = regs[RegA];
            case (op[4:3])
              2'd0: begin cout = {7'd0, v[7]}; regs_next[RegA] = {v[6:0], v[7]}; end
              2'd1: begin cout = {7'd0, v[0]}; regs_next[RegA] = {v[0], v[7:1]}; end
              2'd2: begin cout = {7'd0, v[7]}; regs_next[RegA] = {v[6:0], regs[RegF][4]}; end
              default: begin
                cout = {7'd0, v[0]}; regs_next[RegA] = {regs[RegF][4], v[7:1]};
              end
            endcase
            regs_next[RegF] = cout[0] ? FlagC : 8'h00;
            b.fetch = 1'b1;
          end
          8'h08: begin
            if (s == 3'd1) begin b.address = pc; pc_next = pc + 16'd1; end
            else if (s == 3'd2) begin tw_next = {8'h00, d}; b.address = pc; pc_next = pc + 16'd1; end
            else if (s == 3'd3) begin
              tw_next = {d, tw[7:0]};
              b.address = {d, tw[7:0]}; b.write = 1'b1; b.wr_byte = sp[7:0];
            end else if (s == 3'd4) begin
              b.address = tw + 16'd1; b.write = 1'b1; b.wr_byte = sp[15:8];
            end else b.fetch = 1'b1;
          end
          8'hF8: begin
            if (s == 3'd1) begin b.address = pc; pc_next = pc + 16'd1; end
            else if (s == 3'd2) begin
              e16 = {{8{d[7]}}, d};
              hsum = {1'b0, sp[3:0]} + {1'b0, d[3:0]};
              csum = {1'b0, sp[7:0]} + {1'b0, d};
              a16 = sp + e16;
              regs_next[RegH] = a16[15:8]; regs_next[RegL] = a16[7:0];
              regs_next[RegF] = (hsum[4] ? FlagH : 8'h00) | (csum[8] ? FlagC : 8'h00);
              b.idle = 1'b1;
            end else b.fetch = 1'b1;
          end
          8'hF9: begin
            if (s == 3'd1) begin sp_next = hlw; b.idle = 1'b1; end
            else b.fetch = 1'b1;
          end
          8'h02, 8'h12, 8'h22, 8'h32, 8'h0A, 8'h1A, 8'h2A, 8'h3A: begin
            if (s == 3'd1) begin
              a16 = op[5] ? hlw : prw;
              b.address = a16;
              if (!op[3]) begin b.write = 1'b1; b.wr_byte = regs[RegA]; end
              if (pr == 2'd2) begin
                regs_next[RegH] = 8'(({a16} + 16'd1) >> 8);
                regs_next[RegL] = 8'(a16 + 16'd1);
              end
              if (pr == 2'd3) begin
                regs_next[RegH] = 8'((a16 - 16'd1) >> 8);
                regs_next[RegL] = 8'(a16 - 16'd1);
              end
            end else begin
              if (op[3]) regs_next[RegA] = d;
              b.fetch = 1'b1;
            end
          end
          8'hE0: begin
            if (s == 3'd1) begin b.address = pc; pc_next = pc + 16'd1; end
            else if (s == 3'd2) begin
              b.address = HighPage | {8'h00, d}; b.write = 1'b1; b.wr_byte = regs[RegA];
            end else b.fetch = 1'b1;
          end
          8'hF0: begin
            if (s == 3'd1) begin b.address = pc; pc_next = pc + 16'd1; end
            else if (s == 3'd2) b.address = HighPage | {8'h00, d};
            else begin regs_next[RegA] = d; b.fetch = 1'b1; end
          end
          8'hE2: begin
            if (s == 3'd1) begin
              b.address = HighPage | {8'h00, regs[RegC]};
              b.write = 1'b1; b.wr_byte = regs[RegA];
            end else b.fetch = 1'b1;
          end
          8'hF2: begin
            if (s == 3'd1) b.address = HighPage | {8'h00, regs[RegC]};
            else begin regs_next[RegA] = d; b.fetch = 1'b1; end
          end
          8'hEA, 8'hFA: begin
            if (s == 3'd1) begin b.address = pc; pc_next = pc + 16'd1; end
            else if (s == 3'd2) begin tw_next = {8'h00, d}; b.address = pc; pc_next = pc + 16'd1; end
            else if (s == 3'd3) begin
              tw_next = {d, tw[7:0]};
              b.address = {d, tw[7:0]};
              if (!op[4]) begin b.write = 1'b1; b.wr_byte = regs[RegA]; end
            end else begin
              if (op[4]) regs_next[RegA] = d;
              b.fetch = 1'b1;
            end
          end
          default: begin fault_next = 1'b1; b.idle = 1'b1; end
        endcase
      end
      if (b.fetch) begin
        b.address = pc_next; pc_next = pc_next + 16'd1; sc_next = 3'd1;
      end
    end
    b.halted = stopf_next || fault_next;
    b.bad_opcode = fault_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= BcReset[15:8]; regs[1] <= BcReset[7:0];
      regs[2] <= DeReset[15:8]; regs[3] <= DeReset[7:0];
      regs[4] <= HlReset[15:8]; regs[5] <= HlReset[7:0];
      regs[6] <= AfReset[7:0];  regs[7] <= AfReset[15:8];
      sp <= SpReset; pc <= '0; ir <= '0; sc <= '0; tw <= '0;
      stopf <= 1'b0; fault <= 1'b0;
    end else if (cfg_write) begin
      pc <= cfg_data; sc <= '0;
    end else if (step) begin
      for (int i = 0; i < 8; i++) regs[i] <= regs_next[i];
      sp <= sp_next; pc <= pc_next; ir <= ir_next; sc <= sc_next; tw <= tw_next;
      stopf <= stopf_next; fault <= fault_next;
    end
  end

  assign bus = b;

  `ASSERT_IMPLY(a_fault_halts, clk, rst, fault, bus.halted && bus.idle)
  `ASSERT_IMPLY(a_one_kind, clk, rst, 1'b1, !(bus.write && (bus.idle || bus.fetch)))
  `ASSERT_NEXT(a_fault_sticks, clk, rst, fault && !cfg_write, fault)
endmodule
`default_nettype wire

// ===== sv/eight_bit_cpu_load_rotate_core_top.sv =====
`default_nettype none
// channel  | dir | handshake             | payload
// s_axis   | in  | s_axis_tvalid/tready  | tdata {rd_byte, enable}
// m_axis   | out | m_axis_tvalid/tready  | tdata bus fields, see below
// cfg      | in  | cfg_valid/cfg_ready   | cfg_data start address
// One transaction in, one out; a new item every cycle unless the output is full and not taken.
// The output register stalls only the input side when full and not taken.
// Reset is synchronous and loads the power-on register file with pc at 0.
// A configuration write loads pc and restarts at an opcode fetch.
`include "eight_bit_cpu_load_rotate_core_top_macros.svh"
module eight_bit_cpu_load_rotate_core_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // enable, rd_byte[7:0], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // address, write, wr_byte, idle, fetch,
                                          // halted, bad_opcode, zero pad
);
  import elrc_pkg::*;

  bus_t bus, hold;
  logic step;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  elrc_core u_core (
    .clk(clk), .rst(rst), .cfg_write(cfg_valid), .cfg_data(cfg_data), .step(step),
    .enable(s_axis_tdata[0]), .rd_byte(s_axis_tdata[8:1]), .bus(bus)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (step) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) hold <= bus;
  end

  assign m_axis_tdata = {3'd0, hold.bad_opcode, hold.halted, hold.fetch, hold.idle,
                         hold.wr_byte, hold.write, hold.address};

  `ASSERT_NEXT(a_hold_valid, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_step_valid, clk, rst, step, m_axis_tvalid)
  `ASSERT_IMPLY(a_ready, clk, rst, !m_axis_tvalid, s_axis_tready)
endmodule
`default_nettype wire
